// ----- rtl/spadd_pkg.sv -----
package spadd_pkg;

    localparam int TERMS_PER_POLY = 32;
    localparam int ADDR_W         = (TERMS_PER_POLY > 1) ? $clog2(TERMS_PER_POLY) : 1;
    localparam int CNT_W          = $clog2(TERMS_PER_POLY + 1);
    localparam int COEF_W         = 32;
    localparam int EXPON_W        = 16;
    localparam int REQ_W          = 2;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TERMS_PER_POLY);

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_A = 2'd0,
        REQ_LOAD_B = 2'd1,
        REQ_MERGE  = 2'd2
    } req_code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic [EXPON_W-1:0]       expon;
    } term_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic [EXPON_W-1:0]       expon;
        logic                     last_term;
        logic                     no_terms;
        logic                     terms_dropped;
    } result_t;

    // Saturating Q16.16 add
    function automatic logic signed [COEF_W-1:0] sat_add(
        input logic signed [COEF_W-1:0] x,
        input logic signed [COEF_W-1:0] y
    );
        logic signed [COEF_W:0] s;
        logic signed [COEF_W-1:0] r;
        s = {x[COEF_W-1], x} + {y[COEF_W-1], y};
        if (s[COEF_W] != s[COEF_W-1])
        begin
            r = s[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
        end
        else
        begin
            r = s[COEF_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/spadd_if.sv -----
interface spadd_req_if
    import spadd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [COEF_W-1:0] term_coef;
    logic [EXPON_W-1:0]       term_expon;

    modport source (output valid, req_type, term_coef, term_expon, input ready);
    modport sink (input valid, req_type, term_coef, term_expon, output ready);
endinterface

interface spadd_rsp_if
    import spadd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] result_coef;
    logic [EXPON_W-1:0]       result_expon;
    logic                     last_term;
    logic                     no_terms;
    logic                     terms_dropped;

    modport source (output valid, result_coef, result_expon, last_term, no_terms,
                    terms_dropped, input ready);
    modport sink (input valid, result_coef, result_expon, last_term, no_terms,
                  terms_dropped, output ready);
endinterface

// ----- rtl/spadd_term_store.sv -----
module spadd_term_store
    import spadd_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  term_t             wr_term,
    input  logic [ADDR_W-1:0] rd_addr,
    output term_t             rd_term
);

    term_t mem [TERMS_PER_POLY];
    term_t rd_term_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_term;
        end
        rd_term_reg <= mem[rd_addr];
    end

    assign rd_term = rd_term_reg;

endmodule

// ----- rtl/sparse_polynomial_add_merge.sv -----
// Sparse polynomial adder.
// Requests arrive on 'request': type 0 loads a term (coefficient, exponent) into
// list A, type 1 into list B, type 2 merges; type 3 is taken and ignored. Each
// list holds TERMS_PER_POLY terms, expected in descending exponent order; a
// load into a full list is dropped and flagged on the next merge's results.
// A merge streams terms on 'result' in descending exponent order, matching
// exponents summed with saturation, then clears both lists and the drop flag.
// Both lists empty gives one result with no_terms set and all else zero.
// A merge steps through the states READ and EMIT for each term: READ for the
// synchronous read of both term memories, EMIT to compare and register the
// picked term, returning to IDLE after the last one.
// 'request' is accepted only in IDLE, between merges, so a merge blocks the
// input until its last result is registered.
// A stalled receiver holds the output register and the merge waits on it.
// Reset (rst_n, asynchronous) empties both lists and clears the drop flag;
// memory contents are not cleared and need no clearing pass.
module sparse_polynomial_add_merge
    import spadd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    spadd_req_if.sink    request,
    spadd_rsp_if.source  result
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] a_cnt_reg, b_cnt_reg;
    logic [CNT_W-1:0] ia_reg, ib_reg;
    logic             drop_reg;
    logic             out_valid_reg;
    result_t          out_reg;

    term_t a_rd, b_rd, wr_term;
    logic  a_we, b_we;
    logic  req_fire, is_merge, a_full, b_full;
    logic  out_free, emit_step, empty_fire, finish;
    logic  a_left, b_left, take_a, take_b, last;
    logic [CNT_W-1:0] ia_step, ib_step;
    logic signed [COEF_W-1:0] pick_coef;
    logic [EXPON_W-1:0]       pick_expon;

    assign wr_term.coef  = request.term_coef;
    assign wr_term.expon = request.term_expon;

    spadd_term_store u_store_a (
        .clk     (clk),
        .wr_en   (a_we),
        .wr_addr (a_cnt_reg[ADDR_W-1:0]),
        .wr_term (wr_term),
        .rd_addr (ia_reg[ADDR_W-1:0]),
        .rd_term (a_rd)
    );

    spadd_term_store u_store_b (
        .clk     (clk),
        .wr_en   (b_we),
        .wr_addr (b_cnt_reg[ADDR_W-1:0]),
        .wr_term (wr_term),
        .rd_addr (ib_reg[ADDR_W-1:0]),
        .rd_term (b_rd)
    );

    assign req_fire = request.valid && request.ready;
    assign is_merge = (request.req_type == REQ_MERGE);
    assign a_full   = (a_cnt_reg == CNT_FULL);
    assign b_full   = (b_cnt_reg == CNT_FULL);
    assign out_free = !out_valid_reg || result.ready;

    // Merge step: pick the larger exponent, or both when equal
    always_comb
    begin
        a_left = (ia_reg < a_cnt_reg);
        b_left = (ib_reg < b_cnt_reg);
        take_a = a_left && (!b_left || (a_rd.expon >= b_rd.expon));
        take_b = b_left && (!a_left || (b_rd.expon >= a_rd.expon));
        if (take_a && take_b)
        begin
            pick_coef = sat_add(a_rd.coef, b_rd.coef);
        end
        else if (take_a)
        begin
            pick_coef = a_rd.coef;
        end
        else
        begin
            pick_coef = b_rd.coef;
        end
        pick_expon = take_a ? a_rd.expon : b_rd.expon;
        ia_step    = ia_reg + CNT_W'(take_a);
        ib_step    = ib_reg + CNT_W'(take_b);
        last       = (ia_step == a_cnt_reg) && (ib_step == b_cnt_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && is_merge)
                begin
                    if ((a_cnt_reg == '0) && (b_cnt_reg == '0))
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last ? ST_IDLE : ST_READ;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        request.ready = (state_reg == ST_IDLE);
        a_we          = req_fire && (request.req_type == REQ_LOAD_A) && !a_full;
        b_we          = req_fire && (request.req_type == REQ_LOAD_B) && !b_full;
        emit_step     = (state_reg == ST_EMIT) && out_free;
        empty_fire    = (state_reg == ST_EMPTY) && out_free;
        finish        = (emit_step && last) || empty_fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            a_cnt_reg     <= '0;
            b_cnt_reg     <= '0;
            ia_reg        <= '0;
            ib_reg        <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                a_cnt_reg <= '0;
                b_cnt_reg <= '0;
                ia_reg    <= '0;
                ib_reg    <= '0;
                drop_reg  <= 1'b0;
            end
            else
            begin
                if (a_we)
                begin
                    a_cnt_reg <= a_cnt_reg + 1'b1;
                end
                if (b_we)
                begin
                    b_cnt_reg <= b_cnt_reg + 1'b1;
                end
                if (req_fire && (((request.req_type == REQ_LOAD_A) && a_full) ||
                                 ((request.req_type == REQ_LOAD_B) && b_full)))
                begin
                    drop_reg <= 1'b1;
                end
                if (emit_step)
                begin
                    ia_reg <= ia_step;
                    ib_reg <= ib_step;
                end
            end
            if (emit_step || empty_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_step)
        begin
            out_reg.coef          <= pick_coef;
            out_reg.expon         <= pick_expon;
            out_reg.last_term     <= last;
            out_reg.no_terms      <= 1'b0;
            out_reg.terms_dropped <= drop_reg;
        end
        else if (empty_fire)
        begin
            out_reg.coef          <= '0;
            out_reg.expon         <= '0;
            out_reg.last_term     <= 1'b0;
            out_reg.no_terms      <= 1'b1;
            out_reg.terms_dropped <= 1'b0;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.result_coef   = out_reg.coef;
    assign result.result_expon  = out_reg.expon;
    assign result.last_term     = out_reg.last_term;
    assign result.no_terms      = out_reg.no_terms;
    assign result.terms_dropped = out_reg.terms_dropped;

endmodule

// ----- dv/tb_sparse_polynomial_add_merge.sv -----
`timescale 1ns / 100ps

module tb_sparse_polynomial_add_merge;
    import spadd_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 430;
    localparam int HOLD_START   = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int CALM_FROM    = 250;
    localparam int CALM_TO      = 330;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;

    // Expected-term store plus its own copy of both term lists
    class poly_merge_board;
        term_t       lists[2][TERMS_PER_POLY];
        int unsigned counts[2];
        bit          dropped;
        result_t     expected_terms[$];
        int          errors;

        function new();
            counts[0] = 0;
            counts[1] = 0;
            dropped   = 1'b0;
            errors    = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return expected_terms.size();
        endfunction

        function logic signed [COEF_W-1:0] sat_sum(logic signed [COEF_W-1:0] x,
                                                   logic signed [COEF_W-1:0] y);
            longint s;
            s = x;
            s = s + y;
            if (s > 64'sd2147483647)
                s = 64'sd2147483647;
            else if (s < -64'sd2147483648)
                s = -64'sd2147483648;
            return COEF_W'(s);
        endfunction

        function void push_term(logic signed [COEF_W-1:0] coef, logic [EXPON_W-1:0] expon,
                                bit drop);
            result_t r;
            r               = '0;
            r.coef          = coef;
            r.expon         = expon;
            r.terms_dropped = drop;
            expected_terms.push_back(r);
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic signed [COEF_W-1:0] coef,
                                   logic [EXPON_W-1:0] expon);
            int unsigned ia;
            int unsigned ib;
            term_t       ta;
            term_t       tb;
            result_t     r;
            bit          drop;
            case (req)
                REQ_LOAD_A, REQ_LOAD_B:
                begin
                    if (counts[req[0]] >= TERMS_PER_POLY)
                        dropped = 1'b1;
                    else
                    begin
                        lists[req[0]][counts[req[0]]].coef  = coef;
                        lists[req[0]][counts[req[0]]].expon = expon;
                        counts[req[0]]++;
                    end
                end
                REQ_MERGE:
                begin
                    drop = dropped;
                    if (counts[0] == 0 && counts[1] == 0)
                    begin
                        r          = '0;
                        r.no_terms = 1'b1;
                        expected_terms.push_back(r);
                    end
                    else
                    begin
                        ia = 0;
                        ib = 0;
                        while (ia < counts[0] && ib < counts[1])
                        begin
                            ta = lists[0][ia];
                            tb = lists[1][ib];
                            if (ta.expon < tb.expon)
                            begin
                                push_term(tb.coef, tb.expon, drop);
                                ib++;
                            end
                            else if (ta.expon == tb.expon)
                            begin
                                push_term(sat_sum(ta.coef, tb.coef), ta.expon, drop);
                                ia++;
                                ib++;
                            end
                            else
                            begin
                                push_term(ta.coef, ta.expon, drop);
                                ia++;
                            end
                        end
                        for (; ia < counts[0]; ia++)
                            push_term(lists[0][ia].coef, lists[0][ia].expon, drop);
                        for (; ib < counts[1]; ib++)
                            push_term(lists[1][ib].coef, lists[1][ib].expon, drop);
                        r = expected_terms.pop_back();
                        r.last_term = 1'b1;
                        expected_terms.push_back(r);
                    end
                    counts[0] = 0;
                    counts[1] = 0;
                    dropped   = 1'b0;
                end
                default: ;
            endcase
        endfunction

        task check_result(result_t got);
            result_t want;
            if (expected_terms.size() == 0)
            begin
                report($sformatf("unexpected term coef=%h expon=%h last=%b none=%b drop=%b",
                                 got.coef, got.expon, got.last_term, got.no_terms,
                                 got.terms_dropped));
            end
            else
            begin
                want = expected_terms.pop_front();
                if (got.coef !== want.coef || got.expon !== want.expon
                    || got.last_term !== want.last_term || got.no_terms !== want.no_terms
                    || got.terms_dropped !== want.terms_dropped)
                    report($sformatf({"coef=%h expon=%h last=%b none=%b drop=%b, ",
                                      "expected coef=%h expon=%h last=%b none=%b drop=%b"},
                                     got.coef, got.expon, got.last_term, got.no_terms,
                                     got.terms_dropped, want.coef, want.expon,
                                     want.last_term, want.no_terms, want.terms_dropped));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    spadd_req_if req_if ();
    spadd_rsp_if rsp_if ();

    sparse_polynomial_add_merge dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_if.sink),
        .result  (rsp_if.source)
    );

    poly_merge_board board;
    int              items_sent;
    int              stall_cycles;
    bit              calm;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    assign calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);

    function automatic logic signed [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return COEF_W'($urandom_range(0, 255)) << 16;
            3: return -(COEF_W'($urandom_range(0, 255)) << 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(logic [REQ_W-1:0] req, logic signed [COEF_W-1:0] coef,
                                logic [EXPON_W-1:0] expon);
        while (!calm && $urandom_range(0, 99) < 19)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= req;
        req_if.term_coef  <= coef;
        req_if.term_expon <= expon;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        board.note_request(req, coef, expon);
        if (req != REQ_UNUSED)
            items_sent++;
    endtask

    // Loads na terms into A and nb into B, interleaved, then merges.
    // Sorted lists step down from a shared start so exponents often coincide.
    task automatic run_merge_sequence(int na, int nb, bit sorted);
        int unsigned ea;
        int unsigned eb;
        int unsigned step;
        int          ia;
        int          ib;
        ea = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535);
        eb = ea;
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb)
        begin
            step = $urandom_range(1, 3);
            if (ia < na && (ib >= nb || $urandom_range(0, 1) == 1))
            begin
                send_request(REQ_LOAD_A, pick_coef(),
                             sorted ? EXPON_W'(ea) : EXPON_W'($urandom_range(0, 15)));
                ea = (ea >= step) ? ea - step : 0;
                ia++;
            end
            else
            begin
                send_request(REQ_LOAD_B, pick_coef(),
                             sorted ? EXPON_W'(eb) : EXPON_W'($urandom_range(0, 15)));
                eb = (eb >= step) ? eb - step : 0;
                ib++;
            end
        end
        send_request(REQ_MERGE, $urandom, EXPON_W'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        int roll;
        board             = new();
        items_sent        = 0;
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.req_type   = REQ_LOAD_A;
        req_if.term_coef  = '0;
        req_if.term_expon = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty merge, ignored request type
        send_request(REQ_MERGE, 32'sh7FFF_FFFF, 16'hFFFF);
        send_request(REQ_UNUSED, 32'sh8000_0000, 16'hFFFF);
        // saturation both ways, zero sum, tails, extreme exponents
        send_request(REQ_LOAD_A, 32'sh7FFF_FFFF, 16'hFFFF);
        send_request(REQ_LOAD_B, 32'sh0000_0001, 16'hFFFF);
        send_request(REQ_LOAD_A, 32'sh0001_0000, 16'd100);
        send_request(REQ_LOAD_B, 32'shFFFF_0000, 16'd100);
        send_request(REQ_UNUSED, 32'sh1234_5678, 16'd9);
        send_request(REQ_LOAD_A, 32'sh8000_0000, 16'd50);
        send_request(REQ_LOAD_B, 32'shFFFF_FFFF, 16'd50);
        send_request(REQ_LOAD_B, 32'sh1234_5678, 16'd7);
        send_request(REQ_LOAD_A, 32'shFFFF_0000, 16'd0);
        send_request(REQ_MERGE, '0, '0);
        // one list only
        send_request(REQ_LOAD_B, 32'sh0005_0000, 16'd3);
        send_request(REQ_MERGE, '0, '0);
        send_request(REQ_LOAD_A, 32'sh0000_8000, 16'd0);
        send_request(REQ_MERGE, '0, '0);
        // out of order lists
        send_request(REQ_LOAD_A, 32'sh0002_0000, 16'd1);
        send_request(REQ_LOAD_A, 32'sh0003_0000, 16'd9);
        send_request(REQ_LOAD_B, 32'sh0004_0000, 16'd5);
        send_request(REQ_LOAD_B, 32'sh0006_0000, 16'd9);
        send_request(REQ_MERGE, '0, '0);

        // overflow of A, then both lists full
        run_merge_sequence(34, 3, 1'b1);
        run_merge_sequence(32, 32, 1'b1);
        while (items_sent < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 12)
            begin
                repeat ($urandom_range(1, 4))
                    send_request(REQ_W'($urandom_range(0, 3)), pick_coef(),
                                 EXPON_W'($urandom_range(0, 65535)));
            end
            else if (roll < 16)
                run_merge_sequence($urandom_range(28, 35), $urandom_range(28, 35), 1'b1);
            else if (roll < 25)
                run_merge_sequence($urandom_range(0, 6), $urandom_range(0, 6), 1'b0);
            else
                run_merge_sequence($urandom_range(0, 6), $urandom_range(0, 6), 1'b1);
        end
        req_if.valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // receiver: random back-pressure plus one long hold-off to back the block up
    initial
    begin
        int      hold_left;
        bit      held_once;
        result_t seen;
        hold_left    = 0;
        held_once    = 1'b0;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                seen.coef          = rsp_if.result_coef;
                seen.expon         = rsp_if.result_expon;
                seen.last_term     = rsp_if.last_term;
                seen.no_terms      = rsp_if.no_terms;
                seen.terms_dropped = rsp_if.terms_dropped;
                board.check_result(seen);
            end
            if (!held_once && items_sent >= HOLD_START)
            begin
                hold_left = HOLD_CYCLES;
                held_once = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= calm || ($urandom_range(0, 99) >= 19);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule
